>>> sv/cic_pkg.sv
`timescale 1ns / 1ps

package cic_pkg;

  localparam int FACTOR_W     = 11;
  localparam int PHASE_W      = 10;
  localparam int IN_W         = 16;
  localparam int OUT_W        = 64;
  localparam int RAW_W        = 32;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 11'd8;
  localparam logic [FACTOR_W-1:0] FACTOR_MIN   = 11'd1;
  localparam logic [FACTOR_W-1:0] FACTOR_MAX   = 11'd1024;

  typedef struct packed {
    logic valid;
    logic dump;
  } cic_tag_t;

endpackage

>>> sv/cic_integrator_cell.sv
`timescale 1ns / 1ps

module cic_integrator_cell #(
  parameter int WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cic_pkg::cic_tag_t   tag_in,
  input  logic [WIDTH-1:0]    data_in,
  output cic_pkg::cic_tag_t   tag,
  output logic [WIDTH-1:0]    sum
);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
      sum <= '0;
    end else if (en) begin
      tag <= tag_in;
      if (tag_in.valid) begin
        sum <= sum + data_in;
      end
    end
  end

endmodule

>>> sv/cic_comb_cell.sv
`timescale 1ns / 1ps

module cic_comb_cell #(
  parameter int WIDTH = 64,
  parameter int DELAY = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid_in,
  input  logic [WIDTH-1:0] data_in,
  output logic             valid,
  output logic [WIDTH-1:0] diff
);

  logic [WIDTH-1:0] dly [DELAY];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      diff  <= '0;
      for (int k = 0; k < DELAY; k++) begin
        dly[k] <= '0;
      end
    end else if (en) begin
      valid <= valid_in;
      if (valid_in) begin
        diff   <= data_in - dly[DELAY-1];
        dly[0] <= data_in;
        for (int k = 1; k < DELAY; k++) begin
          dly[k] <= dly[k-1];
        end
      end
    end
  end

endmodule

>>> sv/cic_decimation_filter.sv
// An accepted sample beat is registered through each integrator cell, then each comb cell.
// Throughput: one sample per cycle while no result beat waits under stall; one result per decimation_factor samples.
// The whole cell chain holds only while a result beat waits under stall.
// Reset (rst, synchronous): clears integrators, comb delays, phase and valid
// flags, and sets decimation_factor to 8.
`timescale 1ns / 1ps

module cic_decimation_filter #(
  parameter int SECTIONS     = 4,
  parameter int DIFF_DELAY   = 1,
  parameter int ACC_WIDTH    = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          decimation_factor_we,
  input  logic [cic_pkg::FACTOR_W-1:0]  decimation_factor,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic signed [cic_pkg::IN_W-1:0] sample_in,
  output logic                          filtered_valid,
  input  logic                          filtered_stall,
  output logic signed [cic_pkg::OUT_W-1:0] filtered_out
);

  logic [cic_pkg::FACTOR_W-1:0] factor;
  logic [cic_pkg::FACTOR_W-1:0] factor_eff;
  logic [cic_pkg::PHASE_W-1:0]  phase;
  logic [cic_pkg::PHASE_W-1:0]  phase_next;
  logic [cic_pkg::FACTOR_W-1:0] phase_inc;
  logic                         emit;
  logic                         en;
  logic                         accept;

  logic [cic_pkg::RAW_W-1:0]    raw;
  logic [SAMPLE_WIDTH-1:0]      smp;
  logic signed [cic_pkg::OUT_W-1:0] smp_ext;

  cic_pkg::cic_tag_t            integ_tag  [SECTIONS+1];
  logic [ACC_WIDTH-1:0]         integ_data [SECTIONS+1];
  logic                         comb_valid [SECTIONS+1];
  logic [ACC_WIDTH-1:0]         comb_data  [SECTIONS+1];

  assign en           = !(filtered_valid && filtered_stall);
  assign sample_stall = !en;
  assign accept       = sample_valid && en;

  always_comb begin
    factor_eff = factor;
    if (factor == '0) begin
      factor_eff = cic_pkg::FACTOR_MIN;
    end else if (factor > cic_pkg::FACTOR_MAX) begin
      factor_eff = cic_pkg::FACTOR_MAX;
    end
  end

  assign phase_inc  = {1'b0, phase} + cic_pkg::FACTOR_W'(1);
  assign emit       = (phase_inc >= factor_eff);
  assign phase_next = emit ? '0 : phase_inc[cic_pkg::PHASE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= cic_pkg::FACTOR_RESET;
      phase  <= '0;
    end else begin
      if (decimation_factor_we) begin
        factor <= decimation_factor;
      end
      if (accept) begin
        phase <= phase_next;
      end
    end
  end

  assign raw     = {{(cic_pkg::RAW_W-cic_pkg::IN_W){1'b0}}, sample_in};
  assign smp     = raw[SAMPLE_WIDTH-1:0];
  assign smp_ext = cic_pkg::OUT_W'(signed'(smp));

  assign integ_tag[0].valid = accept;
  assign integ_tag[0].dump  = emit;
  assign integ_data[0]      = smp_ext[ACC_WIDTH-1:0];

  for (genvar i = 0; i < SECTIONS; i++) begin : g_integ
    cic_integrator_cell #(
      .WIDTH(ACC_WIDTH)
    ) u_integ (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .tag_in (integ_tag[i]),
      .data_in(integ_data[i]),
      .tag    (integ_tag[i+1]),
      .sum    (integ_data[i+1])
    );
  end

  assign comb_valid[0] = integ_tag[SECTIONS].valid && integ_tag[SECTIONS].dump;
  assign comb_data[0]  = integ_data[SECTIONS];

  for (genvar i = 0; i < SECTIONS; i++) begin : g_comb
    cic_comb_cell #(
      .WIDTH(ACC_WIDTH),
      .DELAY(DIFF_DELAY)
    ) u_comb (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .valid_in(comb_valid[i]),
      .data_in (comb_data[i]),
      .valid   (comb_valid[i+1]),
      .diff    (comb_data[i+1])
    );
  end

  assign filtered_valid = comb_valid[SECTIONS];
  assign filtered_out   = cic_pkg::OUT_W'(signed'(comb_data[SECTIONS]));

`ifndef ASSERT_OFF
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !filtered_valid)
    else $error("result beat right after reset");

  a_dump_enters_comb: assert property (@(posedge clk) disable iff (rst)
    (en && integ_tag[SECTIONS].valid && integ_tag[SECTIONS].dump) |=> comb_valid[1])
    else $error("dump item lost between integrator and comb chains");

  a_phase_wraps: assert property (@(posedge clk) disable iff (rst)
    (accept && emit) |=> (phase == '0))
    else $error("phase not cleared after block end");

  a_phase_steps: assert property (@(posedge clk) disable iff (rst)
    (accept && !emit) |=> (phase == $past(phase) + cic_pkg::PHASE_W'(1)))
    else $error("phase did not advance");

  a_hold_chain: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(integ_data[SECTIONS]))
    else $error("integrator chain moved while result held");
`endif

endmodule
